/* rtl/rbst_pkg.sv */
// shared constants for the ray versus box slab test
`default_nettype none
package rbst_pkg;
  // fraction bits of every fixed-point coordinate
  localparam int FRAC_BITS = 16;
  // three axes, two slab bounds per axis
  localparam int AXES  = 3;
  localparam int LANES = 6;
endpackage
`default_nettype wire

/* rtl/ray_box_slab_test_top.sv */
// pipelined ray versus axis-aligned box slab test, one word per cycle unless the output stalls
//
//  channel | ports                          | direction | content
//  in      | in_valid / in_ready / in_*     | in        | box corners, ray origin, ray dir
//  out     | out_valid / out_ready / out_hit| out       | hit flag, one per input word
//
// one word enters per cycle unless the output stalls; stages run set-up, the six restoring
// dividers (one quotient bit per pipeline stage), saturate, order, intersect and output.
// rst_n (synchronous, active low) clears every valid bit; payload is not reset.
// the whole pipeline advances whenever the output register is empty or taken,
// so a stall freezes every stage in place and nothing is lost or repeated.
`default_nettype none
module ray_box_slab_test_top #(
  parameter int COORD_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire signed [COORD_BITS-1:0] in_box_min_x,
  input  wire signed [COORD_BITS-1:0] in_box_min_y,
  input  wire signed [COORD_BITS-1:0] in_box_min_z,
  input  wire signed [COORD_BITS-1:0] in_box_max_x,
  input  wire signed [COORD_BITS-1:0] in_box_max_y,
  input  wire signed [COORD_BITS-1:0] in_box_max_z,
  input  wire signed [COORD_BITS-1:0] in_ray_origin_x,
  input  wire signed [COORD_BITS-1:0] in_ray_origin_y,
  input  wire signed [COORD_BITS-1:0] in_ray_origin_z,
  input  wire signed [COORD_BITS-1:0] in_ray_dir_x,
  input  wire signed [COORD_BITS-1:0] in_ray_dir_y,
  input  wire signed [COORD_BITS-1:0] in_ray_dir_z,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_hit
);
  localparam int CB = COORD_BITS;
  localparam int FB = rbst_pkg::FRAC_BITS;
  localparam int NL = rbst_pkg::LANES;
  localparam int NA = rbst_pkg::AXES;
  localparam int W2 = 2 * CB + 1;
  localparam logic [CB-1:0] HALF = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] T_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] T_MAX = {1'b0, {(CB-1){1'b1}}};

  logic en;
  logic out_valid_r, out_hit_r;

  // global advance
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // input vectors by axis
  logic signed [CB-1:0] bmin [0:NA-1];
  logic signed [CB-1:0] bmax [0:NA-1];
  logic signed [CB-1:0] org  [0:NA-1];
  logic signed [CB-1:0] dir  [0:NA-1];
  assign bmin[0] = in_box_min_x;    assign bmin[1] = in_box_min_y;
  assign bmin[2] = in_box_min_z;
  assign bmax[0] = in_box_max_x;    assign bmax[1] = in_box_max_y;
  assign bmax[2] = in_box_max_z;
  assign org[0]  = in_ray_origin_x; assign org[1]  = in_ray_origin_y;
  assign org[2]  = in_ray_origin_z;
  assign dir[0]  = in_ray_dir_x;    assign dir[1]  = in_ray_dir_y;
  assign dir[2]  = in_ray_dir_z;

  // divider pipeline registers, index 0 is the set-up stage
  logic          v_r    [0:CB];
  logic [CB-1:0] rem_r  [0:CB][0:NL-1];
  logic [CB-1:0] numb_r [0:CB][0:NL-1];
  logic [CB-1:0] q_r    [0:CB][0:NL-1];
  logic [CB-1:0] dv_r   [0:CB][0:NL-1];
  logic [NL-1:0] neg_r  [0:CB];
  logic [NL-1:0] ovf_r  [0:CB];
  logic [NA-1:0] dz_r   [0:CB];
  logic          miss_r [0:CB];

  // set-up: differences, magnitudes, signs, overflow, zero-direction flags, early miss and first remainder
  logic [CB-1:0] rem_nxt  [0:NL-1];
  logic [CB-1:0] numb_nxt [0:NL-1];
  logic [CB-1:0] dv_nxt   [0:NL-1];
  logic [NL-1:0] neg_nxt, ovf_nxt;
  logic [NA-1:0] dz_nxt;
  logic          miss_nxt;

  always_comb begin
    logic signed [CB:0] diff;
    logic [CB:0]        an;
    logic [CB:0]        top;
    logic [CB:0]        low;
    logic [CB-1:0]      ad;
    logic [W2-1:0]      adsh;
    logic               org_in;
    miss_nxt = 1'b0;
    neg_nxt  = '0;
    ovf_nxt  = '0;
    dz_nxt   = '0;
    for (int l = 0; l < NL; l++) begin
      if (l % 2 == 0) begin
        diff = {bmin[l/2][CB-1], bmin[l/2]} - {org[l/2][CB-1], org[l/2]};
      end else begin
        diff = {bmax[l/2][CB-1], bmax[l/2]} - {org[l/2][CB-1], org[l/2]};
      end
      an   = diff[CB] ? (CB+1)'(-diff) : (CB+1)'(diff);
      ad   = dir[l/2][CB-1] ? CB'(-dir[l/2]) : CB'(dir[l/2]);
      top  = an >> (CB - FB);
      low  = an << FB;
      adsh = W2'(ad) << (CB - FB);
      rem_nxt[l]  = top[CB-1:0];
      numb_nxt[l] = low[CB-1:0];
      dv_nxt[l]   = ad;
      neg_nxt[l]  = diff[CB] ^ dir[l/2][CB-1];
      ovf_nxt[l]  = W2'(an) >= adsh;
    end
    for (int a = 0; a < NA; a++) begin
      dz_nxt[a] = dir[a] == '0;
      org_in    = (org[a] >= bmin[a]) && (org[a] <= bmax[a]);
      if (dz_nxt[a] && !org_in) begin
        miss_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        rem_r[0][l]  <= rem_nxt[l];
        numb_r[0][l] <= numb_nxt[l];
        dv_r[0][l]   <= dv_nxt[l];
        q_r[0][l]    <= '0;
      end
      neg_r[0]  <= neg_nxt;
      ovf_r[0]  <= ovf_nxt;
      dz_r[0]   <= dz_nxt;
      miss_r[0] <= miss_nxt;
    end
  end

  // restoring division, one quotient bit per stage for all six lanes
  for (genvar k = 1; k <= CB; k++) begin : g_step
    logic [CB:0]   rs   [0:NL-1];
    logic [CB:0]   sub  [0:NL-1];
    logic [CB-1:0] rn   [0:NL-1];
    logic          qb   [0:NL-1];
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        rs[l]  = {rem_r[k-1][l], numb_r[k-1][l][CB-1]};
        sub[l] = rs[l] - {1'b0, dv_r[k-1][l]};
        qb[l]  = !sub[l][CB];
        rn[l]  = qb[l] ? sub[l][CB-1:0] : rs[l][CB-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        for (int l = 0; l < NL; l++) begin
          rem_r[k][l]  <= rn[l];
          numb_r[k][l] <= numb_r[k-1][l] << 1;
          q_r[k][l]    <= {q_r[k-1][l][CB-2:0], qb[l]};
          dv_r[k][l]   <= dv_r[k-1][l];
        end
        neg_r[k]  <= neg_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        dz_r[k]   <= dz_r[k-1];
        miss_r[k] <= miss_r[k-1];
      end
    end
  end

  // saturate and apply sign
  logic                 va_r, miss_a_r;
  logic [NA-1:0]        dz_a_r;
  logic signed [CB-1:0] t_r [0:NL-1];
  logic signed [CB-1:0] t_nxt [0:NL-1];

  always_comb begin
    logic [CB-1:0] lim;
    logic [CB-1:0] m;
    for (int l = 0; l < NL; l++) begin
      lim = neg_r[CB][l] ? HALF : HALF - CB'(1);
      m   = (ovf_r[CB][l] || q_r[CB][l] > lim) ? lim : q_r[CB][l];
      t_nxt[l] = neg_r[CB][l] ? -$signed(m) : $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_r[CB];
    end
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        t_r[l] <= t_nxt[l];
      end
      dz_a_r   <= dz_r[CB];
      miss_a_r <= miss_r[CB];
    end
  end

  // order each pair, free axes take the full range
  logic                 vb_r, miss_b_r;
  logic signed [CB-1:0] lo_r [0:NA-1];
  logic signed [CB-1:0] hi_r [0:NA-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        if (dz_a_r[a]) begin
          lo_r[a] <= T_MIN;
          hi_r[a] <= T_MAX;
        end else if (t_r[2*a] > t_r[2*a+1]) begin
          lo_r[a] <= t_r[2*a+1];
          hi_r[a] <= t_r[2*a];
        end else begin
          lo_r[a] <= t_r[2*a];
          hi_r[a] <= t_r[2*a+1];
        end
      end
      miss_b_r <= miss_a_r;
    end
  end

  // intersect the three intervals
  logic                 vc_r, miss_c_r;
  logic signed [CB-1:0] tlo_r, thi_r;
  logic signed [CB-1:0] tlo_nxt, thi_nxt;

  always_comb begin
    tlo_nxt = (lo_r[0] > lo_r[1]) ? lo_r[0] : lo_r[1];
    if (lo_r[2] > tlo_nxt) begin
      tlo_nxt = lo_r[2];
    end
    thi_nxt = (hi_r[0] < hi_r[1]) ? hi_r[0] : hi_r[1];
    if (hi_r[2] < thi_nxt) begin
      thi_nxt = hi_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
    if (en) begin
      tlo_r    <= tlo_nxt;
      thi_r    <= thi_nxt;
      miss_c_r <= miss_b_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vc_r;
    end
    if (en) begin
      out_hit_r <= !miss_c_r && !(tlo_r > thi_r);
    end
  end

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");
  a_word_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && vc_r |=> out_valid_r)
    else $error("finished word lost before output");
  a_bubble_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    en && !vc_r |=> !out_valid_r)
    else $error("output word invented from a bubble");
  a_miss_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    en && vc_r && miss_c_r |=> !out_hit_r)
    else $error("hit reported on a missed zero-direction axis");

endmodule
`default_nettype wire
